// ----- hdl/miu_pkg.sv -----
package miu_pkg;

	localparam logic [31:0] SignBit    = 32'h8000_0000;
	localparam logic [31:0] AllOnes    = 32'hffff_ffff;
	localparam logic [31:0] RegionMask = 32'hf000_0000;
	localparam logic [4:0]  LinkReg    = 5'd31;

	localparam logic [2:0] ExcNone     = 3'd0;
	localparam logic [2:0] ExcOverflow = 3'd1;
	localparam logic [2:0] ExcReserved = 3'd2;
	localparam logic [2:0] ExcSyscall  = 3'd3;
	localparam logic [2:0] ExcBreak    = 3'd4;
	localparam logic [2:0] ExcAddrLoad = 3'd5;
	localparam logic [2:0] ExcNotDone  = 3'd6;

	// long-running HI/LO operations
	typedef enum logic [1:0] {
		LONG_MULT,
		LONG_MULTU,
		LONG_DIV,
		LONG_DIVU
	} long_op_t;

	// controller -> datapath
	typedef struct packed {
		logic     load;      // capture input item and its decoded result
		logic     start_md;  // begin multiply/divide sequence
		logic     step_md;   // one iteration
		logic     finish_md; // write HI/LO from sequence
	} miu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_long; // captured item needs the multiply/divide sequence
		logic md_last; // iteration counter at final step
	} miu_status_t;

endpackage

// ----- hdl/miu_ctrl.sv -----
module miu_ctrl
	import miu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  miu_status_t status,
	output miu_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_ITER,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// a new item may enter when idle and the previous result is gone or leaving
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.start_md  = (state_q == ST_DECIDE) && status.is_long;
		cmd.step_md   = (state_q == ST_ITER);
		cmd.finish_md = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (status.is_long) begin
						state_q <= ST_ITER;
					end else begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				ST_ITER: begin
					if (status.md_last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/miu_datapath.sv -----
module miu_datapath
	import miu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  miu_cmd_t    cmd,
	output miu_status_t status,
	input  logic [31:0] instr_word,
	input  logic [31:0] rs_value,
	input  logic [31:0] rt_value,
	input  logic [31:0] cur_pc,
	input  logic [31:0] link_pc,
	output logic        write_enable,
	output logic [4:0]  write_index,
	output logic [31:0] write_value,
	output logic        branch_taken,
	output logic [31:0] branch_target,
	output logic        delay_slot_next,
	output logic [2:0]  exc_code,
	output logic [31:0] bad_address
);

	logic [31:0] hi_q, lo_q;

	// decoded result of the current item
	logic        we_c, bt_c, ds_c, long_c;
	logic [4:0]  wi_c;
	logic [31:0] wv_c, tgt_c, bad_c;
	logic [2:0]  exc_c;
	logic        set_hi_c, set_lo_c;
	long_op_t    lop_c;

	logic [5:0]  op, fn;
	logic [4:0]  rt, rd, sh, sv;
	logic [31:0] imm, simm, btgt, jtgt, sum, diff, addi;
	logic        ovf_add, ovf_sub, ovf_addi, cond;

	always_comb begin
		op   = instr_word[31:26];
		fn   = instr_word[5:0];
		rt   = instr_word[20:16];
		rd   = instr_word[15:11];
		sh   = instr_word[10:6];
		sv   = rs_value[4:0];
		imm  = {16'd0, instr_word[15:0]};
		simm = {{16{instr_word[15]}}, instr_word[15:0]};
		btgt = cur_pc + {simm[29:0], 2'b00};
		jtgt = (link_pc & RegionMask) | {4'd0, instr_word[25:0], 2'b00};
		sum  = rs_value + rt_value;
		diff = rs_value - rt_value;
		addi = rs_value + simm;
		ovf_add  = (rs_value[31] == rt_value[31]) && (sum[31] != rs_value[31]);
		ovf_sub  = (rs_value[31] != rt_value[31]) && (diff[31] != rs_value[31]);
		ovf_addi = (rs_value[31] == simm[31]) && (addi[31] != rs_value[31]);
		cond     = rt[0] ? !rs_value[31] : rs_value[31];

		we_c = 1'b0; wi_c = '0; wv_c = '0; bt_c = 1'b0; tgt_c = '0;
		ds_c = 1'b0; exc_c = ExcNone; bad_c = '0; long_c = 1'b0;
		set_hi_c = 1'b0; set_lo_c = 1'b0; lop_c = LONG_MULT;

		case (op)
			6'd0: begin
				wi_c = rd;
				we_c = 1'b1;
				case (fn)
					6'd0:  wv_c = rt_value << sh;
					6'd2:  wv_c = rt_value >> sh;
					6'd3:  wv_c = 32'($signed(rt_value) >>> sh);
					6'd4:  wv_c = rt_value << sv;
					6'd6:  wv_c = rt_value >> sv;
					6'd7:  wv_c = 32'($signed(rt_value) >>> sv);
					6'd8, 6'd9: begin
						we_c  = (fn == 6'd9);
						wv_c  = link_pc;
						ds_c  = 1'b1;
						tgt_c = rs_value;
						if (rs_value[1:0] != 2'b00) begin
							exc_c = ExcAddrLoad;
							bad_c = rs_value;
						end else begin
							bt_c = 1'b1;
						end
					end
					6'd12: begin we_c = 1'b0; exc_c = ExcSyscall; end
					6'd13: begin we_c = 1'b0; exc_c = ExcBreak; end
					6'd16: wv_c = hi_q;
					6'd17: begin we_c = 1'b0; set_hi_c = 1'b1; end
					6'd18: wv_c = lo_q;
					6'd19: begin we_c = 1'b0; set_lo_c = 1'b1; end
					6'd24: begin we_c = 1'b0; long_c = 1'b1; lop_c = LONG_MULT; end
					6'd25: begin we_c = 1'b0; long_c = 1'b1; lop_c = LONG_MULTU; end
					6'd26: begin we_c = 1'b0; long_c = 1'b1; lop_c = LONG_DIV; end
					6'd27: begin we_c = 1'b0; long_c = 1'b1; lop_c = LONG_DIVU; end
					6'd32: begin
						wv_c = sum;
						if (ovf_add) begin we_c = 1'b0; exc_c = ExcOverflow; end
					end
					6'd33: wv_c = sum;
					6'd34: begin
						wv_c = diff;
						if (ovf_sub) begin we_c = 1'b0; exc_c = ExcOverflow; end
					end
					6'd35: wv_c = diff;
					6'd36: wv_c = rs_value & rt_value;
					6'd37: wv_c = rs_value | rt_value;
					6'd38: wv_c = rs_value ^ rt_value;
					6'd39: wv_c = ~(rs_value | rt_value);
					6'd42: wv_c = {31'd0, $signed(rs_value) < $signed(rt_value)};
					6'd43: wv_c = {31'd0, rs_value < rt_value};
					default: begin we_c = 1'b0; exc_c = ExcReserved; end
				endcase
			end
			6'd1: begin
				we_c  = (rt[4:1] == 4'b1000);
				wi_c  = LinkReg;
				wv_c  = link_pc;
				ds_c  = 1'b1;
				tgt_c = btgt;
				bt_c  = cond;
			end
			6'd2: begin ds_c = 1'b1; tgt_c = jtgt; bt_c = 1'b1; end
			6'd3: begin
				we_c = 1'b1; wi_c = LinkReg; wv_c = link_pc;
				ds_c = 1'b1; tgt_c = jtgt; bt_c = 1'b1;
			end
			6'd4: begin ds_c = 1'b1; tgt_c = btgt; bt_c = (rs_value == rt_value); end
			6'd5: begin ds_c = 1'b1; tgt_c = btgt; bt_c = (rs_value != rt_value); end
			6'd6: begin ds_c = 1'b1; tgt_c = btgt; bt_c = $signed(rs_value) < 32'sd1; end
			6'd7: begin ds_c = 1'b1; tgt_c = btgt; bt_c = $signed(rs_value) > 32'sd0; end
			6'd8: begin
				wi_c = rt; wv_c = addi;
				if (ovf_addi) exc_c = ExcOverflow; else we_c = 1'b1;
			end
			6'd9:  begin wi_c = rt; wv_c = addi; we_c = 1'b1; end
			6'd10: begin
				wi_c = rt; we_c = 1'b1;
				wv_c = {31'd0, $signed(rs_value) < $signed(simm)};
			end
			6'd11: begin wi_c = rt; we_c = 1'b1; wv_c = {31'd0, rs_value < simm}; end
			6'd12: begin wi_c = rt; we_c = 1'b1; wv_c = rs_value & imm; end
			6'd13: begin wi_c = rt; we_c = 1'b1; wv_c = rs_value | imm; end
			6'd14: begin wi_c = rt; we_c = 1'b1; wv_c = rs_value ^ imm; end
			6'd15: begin wi_c = rt; we_c = 1'b1; wv_c = {instr_word[15:0], 16'd0}; end
			6'd16, 6'd17, 6'd18, 6'd19,
			6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
			6'd40, 6'd41, 6'd42, 6'd43, 6'd46,
			6'd48, 6'd49, 6'd50, 6'd51,
			6'd56, 6'd57, 6'd58, 6'd59: exc_c = ExcNotDone;
			default: exc_c = ExcReserved;
		endcase

		// register zero is never written
		if (wi_c == 5'd0)
			we_c = 1'b0;
		if (!we_c) begin
			wi_c = '0;
			wv_c = '0;
		end
	end

	// result registers
	logic        we_q, bt_q, ds_q, long_q;
	logic [4:0]  wi_q;
	logic [31:0] wv_q, tgt_q, bad_q, a_q, b_q;
	logic [2:0]  exc_q;
	long_op_t    lop_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			we_q <= we_c; wi_q <= wi_c; wv_q <= wv_c;
			bt_q <= bt_c; tgt_q <= tgt_c; ds_q <= ds_c;
			exc_q <= exc_c; bad_q <= bad_c; long_q <= long_c;
			lop_q <= lop_c; a_q <= rs_value; b_q <= rt_value;
		end
	end

	assign write_enable    = we_q;
	assign write_index     = wi_q;
	assign write_value     = wv_q;
	assign branch_taken    = bt_q;
	assign branch_target   = tgt_q;
	assign delay_slot_next = ds_q;
	assign exc_code        = exc_q;
	assign bad_address     = bad_q;

	// shift-add multiply / restoring divide on magnitudes, one bit per step
	logic [31:0] acc_q, md_q, dvs_q;
	logic [4:0]  cnt_q;
	logic        neg_q_q, neg_r_q, is_div_q;
	logic        a_neg, b_neg, sgn;
	logic [31:0] ma, mb;
	logic [32:0] madd, dtry;
	logic [31:0] rem_sh;
	logic [63:0] prod, prod_n;
	logic [31:0] quo, rem, quo_n, rem_n;

	always_comb begin
		sgn   = (lop_q == LONG_MULT) || (lop_q == LONG_DIV);
		a_neg = sgn && a_q[31];
		b_neg = sgn && b_q[31];
		ma    = a_neg ? (32'd0 - a_q) : a_q;
		mb    = b_neg ? (32'd0 - b_q) : b_q;
		madd  = {1'b0, acc_q} + (md_q[0] ? {1'b0, dvs_q} : 33'd0);
		rem_sh = {acc_q[30:0], md_q[31]};
		dtry  = {acc_q, md_q[31]} - {1'b0, dvs_q};
		prod   = {acc_q, md_q};
		prod_n = 64'd0 - prod;
		quo    = md_q;
		rem    = acc_q;
		quo_n  = 32'd0 - quo;
		rem_n  = 32'd0 - rem;
	end

	assign status.is_long = long_q;
	assign status.md_last = (cnt_q == 5'd31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (cmd.load && set_hi_c) begin
			hi_q <= rs_value;
		end else if (cmd.load && set_lo_c) begin
			lo_q <= rs_value;
		end else if (cmd.finish_md) begin
			if (!is_div_q) begin
				lo_q <= neg_q_q ? prod_n[31:0] : prod[31:0];
				hi_q <= neg_q_q ? prod_n[63:32] : prod[63:32];
			end else if (b_q == 32'd0) begin
				lo_q <= (lop_q == LONG_DIV && a_q[31]) ? 32'd1 : AllOnes;
				hi_q <= a_q;
			end else if (lop_q == LONG_DIV && a_q == SignBit && b_q == AllOnes) begin
				lo_q <= SignBit;
				hi_q <= '0;
			end else begin
				lo_q <= neg_q_q ? quo_n : quo;
				hi_q <= neg_r_q ? rem_n : rem;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_md) begin
			acc_q    <= '0;
			md_q     <= ma;
			dvs_q    <= mb;
			cnt_q    <= '0;
			is_div_q <= (lop_q == LONG_DIV) || (lop_q == LONG_DIVU);
			neg_q_q  <= a_neg ^ b_neg;
			neg_r_q  <= a_neg;
		end else if (cmd.step_md) begin
			cnt_q <= cnt_q + 5'd1;
			if (!is_div_q) begin
				{acc_q, md_q} <= {madd, md_q[31:1]};
			end else if (!dtry[32]) begin
				acc_q <= dtry[31:0];
				md_q  <= {md_q[30:0], 1'b1};
			end else begin
				acc_q <= rem_sh;
				md_q  <= {md_q[30:0], 1'b0};
			end
		end
	end

endmodule

// ----- hdl/mips_integer_execute_unit.sv -----
// Results: the decoded result is registered at the input transfer and output valid rises after
// the decide state; MULT/MULTU/DIV/DIVU go through decide, 32 iterations and the HI/LO write-back.
// A new item is taken only in the idle state and not while a held result waits for out_ready;
// multiply and divide are set by the one-bit-per-cycle shift/add and restoring-divide loop.
// Reset (arst_n low) clears HI, LO, the controller state and output valid.
module mips_integer_execute_unit
	import miu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instr_word,
	input  logic [31:0] rs_value,
	input  logic [31:0] rt_value,
	input  logic [31:0] cur_pc,
	input  logic [31:0] link_pc,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_enable,
	output logic [4:0]  write_index,
	output logic [31:0] write_value,
	output logic        branch_taken,
	output logic [31:0] branch_target,
	output logic        delay_slot_next,
	output logic [2:0]  exc_code,
	output logic [31:0] bad_address
);

	miu_cmd_t    cmd;
	miu_status_t status;

	miu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	miu_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.instr_word      (instr_word),
		.rs_value        (rs_value),
		.rt_value        (rt_value),
		.cur_pc          (cur_pc),
		.link_pc         (link_pc),
		.write_enable    (write_enable),
		.write_index     (write_index),
		.write_value     (write_value),
		.branch_taken    (branch_taken),
		.branch_target   (branch_target),
		.delay_slot_next (delay_slot_next),
		.exc_code        (exc_code),
		.bad_address     (bad_address)
	);

endmodule

// ----- hdl/miu_checker.sv -----
module miu_checker
	import miu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        write_enable,
	input logic [4:0]  write_index,
	input logic        branch_taken,
	input logic        delay_slot_next,
	input logic [2:0]  exc_code
);

	// result is not valid in the cycle after its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result valid right after input transfer");

	// held result stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> write_index != 5'd0)
		else $error("write to register zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && branch_taken |-> delay_slot_next && exc_code == ExcNone)
		else $error("taken branch without delay slot or with exception");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> exc_code != 3'd7)
		else $error("undefined exception code");

endmodule

bind mips_integer_execute_unit miu_checker u_miu_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.write_enable    (write_enable),
	.write_index     (write_index),
	.branch_taken    (branch_taken),
	.delay_slot_next (delay_slot_next),
	.exc_code        (exc_code)
);
